/* rtl/fcmc_pkg.sv */
// fcmc_pkg: shared constants and types for the fifo cache miss counter
// used by every module of the block; depends on nothing

package fcmc_pkg;

  // store geometry
  localparam int ENTRIES  = 128;
  localparam int KEY_BITS = 10;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  // register and field widths
  localparam int CFG_W    = 8;
  localparam int COUNT_W  = 16;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 24;
  localparam int ADDR_W   = 3;

  // register index decoded from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic write;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_issue;
    logic out_free;
  } status_t;

endpackage

/* rtl/fcmc_regs.sv */
// fcmc_regs: apb register block holding the capacity in use
// depends on fcmc_pkg

module fcmc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcmc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [fcmc_pkg::CNT_W-1:0] cap_o
);
  import fcmc_pkg::*;

  logic [CFG_W-1:0] cap_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_CAPACITY);

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CFG_W'(1);
    end else if (wr_en) begin
      cap_q <= pwdata[CFG_W-1:0];
    end
  end

  // read back
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CFG_W){1'b0}}, cap_q} : 32'd0;

  // zero counts as one, large values clip to the built depth
  always_comb begin
    if (cap_q == '0) begin
      cap_o = CNT_W'(1);
    end else if (int'(cap_q) > ENTRIES) begin
      cap_o = CNT_W'(ENTRIES);
    end else begin
      cap_o = CNT_W'(cap_q);
    end
  end

endmodule

/* rtl/fcmc_ctrl.sv */
// fcmc_ctrl: state machine sequencing accept, scan, compare drain and update
// depends on fcmc_pkg

module fcmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  fcmc_pkg::status_t status_i,
  output fcmc_pkg::cmd_t    cmd_o
);
  import fcmc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_WRITE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign s_axis_tready = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.last_issue) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/fcmc_dpath.sv */
// fcmc_dpath: key memory, valid marks, insert pointer, miss count and result register
// depends on fcmc_pkg

module fcmc_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [fcmc_pkg::CNT_W-1:0]  cap_i,
  input  logic [fcmc_pkg::IN_W-1:0]   s_axis_tdata,   // [9:0] word_key, rest zero
  input  logic                        s_axis_tlast,   // end_of_text
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [fcmc_pkg::OUT_W-1:0]  m_axis_tdata,   // [0] was_miss, [16:1] miss_total
  output logic                        m_axis_tlast,   // final_result
  input  fcmc_pkg::cmd_t              cmd_i,
  output fcmc_pkg::status_t           status_o
);
  import fcmc_pkg::*;

  logic [KEY_BITS-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0]  valid_q;
  logic [KEY_BITS-1:0] key_q;
  logic                eot_q;
  logic [CNT_W-1:0]    idx_q;
  logic [CNT_W-1:0]    ptr_q, ptr_d, ptr_eff;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [KEY_BITS-1:0] rd_key_q;
  logic                rd_vld_q;
  logic                cmp_v_q;
  logic                hit_q;
  logic                miss;
  logic                out_valid_q;
  logic                out_miss_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic                out_last_q;

  assign status_o.last_issue = (idx_q == cap_i - CNT_W'(1));
  assign status_o.out_free   = !out_valid_q || m_axis_tready;

  // request capture and scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= s_axis_tdata[KEY_BITS-1:0];
      eot_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + CNT_W'(1);
    end
  end

  // key memory: registered read during scan, write on miss
  always_ff @(posedge clk_i) begin
    rd_key_q <= mem[idx_q[IDX_W-1:0]];
    if (cmd_i.write && miss) begin
      mem[ptr_eff[IDX_W-1:0]] <= key_q;
    end
  end

  // compare pipeline and hit accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_v_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      cmp_v_q  <= cmd_i.scan;
      rd_vld_q <= valid_q[idx_q[IDX_W-1:0]];
      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end else if (cmp_v_q && rd_vld_q && (rd_key_q == key_q)) begin
        hit_q <= 1'b1;
      end
    end
  end

  // insert pointer wraps at the capacity in use, count saturates
  assign miss    = !hit_q;
  assign ptr_eff = (ptr_q >= cap_i) ? '0 : ptr_q;
  assign ptr_d   = ptr_eff + CNT_W'(1);
  assign count_d = (miss && (count_q != '1)) ? count_q + COUNT_W'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.write && miss) begin
      valid_q[ptr_eff[IDX_W-1:0]] <= 1'b1;
      ptr_q   <= ptr_d;
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      out_miss_q  <= miss;
      out_count_q <= count_d;
      out_last_q  <= eot_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_W-COUNT_W-1){1'b0}}, out_count_q, out_miss_q};
  assign m_axis_tlast  = out_last_q;

  // pointer never runs past the built depth
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(ptr_q) <= ENTRIES)
    else $error("insert pointer beyond depth");

  // scan reads only entries inside the capacity in use
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (idx_q < cap_i))
    else $error("scan index beyond capacity");

  // miss count never goes down
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= $past(count_q))
    else $error("miss count decreased");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> (!out_valid_q || m_axis_tready))
    else $error("result overwritten");

endmodule

/* rtl/fifo_cache_miss_counter.sv */
// fifo_cache_miss_counter: top level joining registers, controller and datapath
// depends on fcmc_pkg, fcmc_regs, fcmc_ctrl, fcmc_dpath

// Fully associative word cache with first-in-first-out replacement and a
// saturating 16-bit miss counter. Each request passes through an accept
// state, a scan over the entries in use (a capacity of zero counts as one,
// values above 128 count as 128) as the key memory is read and compared one
// entry at a time through its single registered read port, a state to drain
// the compare and an update state. The update waits while an older result
// still sits unaccepted in the output register. A new request is accepted once
// the previous one is updated, while its result may still wait in the output
// register. Valid marks sit in flip-flops cleared by reset, so no clearing pass
// runs after reset. Write capacity_in_use (byte address 0, bits [7:0]) only
// while the block is idle.

module fifo_cache_miss_counter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input requests
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [fcmc_pkg::IN_W-1:0]   s_axis_tdata,   // [9:0] word_key, rest zero
  input  logic                        s_axis_tlast,   // end_of_text
  // results
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [fcmc_pkg::OUT_W-1:0]  m_axis_tdata,   // [0] was_miss, [16:1] miss_total
  output logic                        m_axis_tlast,   // final_result
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcmc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fcmc_pkg::*;

  logic [CNT_W-1:0] cap;
  cmd_t             cmd;
  status_t          status;

  // configuration registers
  fcmc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  // sequencing
  fcmc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // storage and result path
  fcmc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cap_i         (cap),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
